// ===== design/lifo_stack_with_reverse_assert.svh =====
// assertion macros for the lifo stack
`ifndef LIFO_STACK_WITH_REVERSE_ASSERT_SVH
`define LIFO_STACK_WITH_REVERSE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lsr_pkg.sv =====
package lsr_pkg;

  localparam int DEPTH   = 16;
  localparam int WORD_W  = 32;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 5;

  localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
  localparam logic [OP_W-1:0] OP_REVERSE = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] push_value;
  } lsr_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic [ST_W-1:0]          status;
    logic [COUNT_W-1:0]       entry_count;
  } lsr_out_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
  } lsr_mem_req_t;

  function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+COUNT_W-1:0] wide;
    wide = {{COUNT_W{1'b0}}, cnt};
    return wide[COUNT_W-1:0];
  endfunction

endpackage

// ===== design/lsr_mem.sv =====
module lsr_mem (
  input  logic                 clk,
  input  lsr_pkg::lsr_mem_req_t req,
  output logic [lsr_pkg::WORD_W-1:0] rd_a,
  output logic [lsr_pkg::WORD_W-1:0] rd_b
);
  import lsr_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_a <= mem[req.rd_addr_a];
      rd_b <= mem[req.rd_addr_b];
    end
  end

endmodule

// ===== design/lsr_ctrl.sv =====
module lsr_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  lsr_pkg::lsr_in_t            in_data,
  output logic                        in_stall,
  input  logic                        out_free,
  output logic                        res_load,
  output lsr_pkg::lsr_out_t           res_data,
  output lsr_pkg::lsr_mem_req_t       mem_req,
  input  logic [lsr_pkg::WORD_W-1:0]  rd_a,
  input  logic [lsr_pkg::WORD_W-1:0]  rd_b
);
  import lsr_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_WAIT = 3'd1;
  localparam logic [2:0] S_REV_RD  = 3'd2;
  localparam logic [2:0] S_REV_W1  = 3'd3;
  localparam logic [2:0] S_REV_W2  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [ADDR_W-1:0] lo_r, lo_nxt;
  logic [ADDR_W-1:0] hi_r, hi_nxt;

  logic [CNT_W-1:0]  fill_inc, fill_dec;
  logic [ADDR_W-1:0] lo_inc, hi_dec;
  logic              accept;

  assign fill_inc = fill_r + CNT_W'(1);
  assign fill_dec = fill_r - CNT_W'(1);
  assign lo_inc   = lo_r + ADDR_W'(1);
  assign hi_dec   = hi_r - ADDR_W'(1);

  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt             = state_r;
    fill_nxt              = fill_r;
    lo_nxt                = lo_r;
    hi_nxt                = hi_r;
    mem_req               = '0;
    res_load              = 1'b0;
    res_data.result_value = '0;
    res_data.status       = ST_OK;
    res_data.entry_count  = count_field(fill_r);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_PUSH: begin
              res_load = 1'b1;
              if (fill_r == CNT_W'(DEPTH)) begin
                res_data.status = ST_OVERFLOW;
              end else begin
                mem_req.wr_en        = 1'b1;
                mem_req.wr_addr      = fill_r[ADDR_W-1:0];
                mem_req.wr_data      = in_data.push_value;
                fill_nxt             = fill_inc;
                res_data.entry_count = count_field(fill_inc);
              end
            end
            OP_POP, OP_PEEK: begin
              if (fill_r == '0) begin
                res_load        = 1'b1;
                res_data.status = ST_EMPTY;
              end else begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = fill_dec[ADDR_W-1:0];
                mem_req.rd_addr_b = fill_dec[ADDR_W-1:0];
                if (in_data.operation == OP_POP) begin
                  fill_nxt = fill_dec;
                end
                state_nxt = S_RD_WAIT;
              end
            end
            default: begin
              if (fill_r < CNT_W'(2)) begin
                res_load = 1'b1;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = fill_dec[ADDR_W-1:0];
                state_nxt = S_REV_RD;
              end
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        res_load              = 1'b1;
        res_data.result_value = rd_a;
        state_nxt             = S_IDLE;
      end
      S_REV_RD: begin
        mem_req.rd_en     = 1'b1;
        mem_req.rd_addr_a = lo_r;
        mem_req.rd_addr_b = hi_r;
        state_nxt         = S_REV_W1;
      end
      S_REV_W1: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = lo_r;
        mem_req.wr_data = rd_b;
        state_nxt       = S_REV_W2;
      end
      S_REV_W2: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = hi_r;
        mem_req.wr_data = rd_a;
        lo_nxt          = lo_inc;
        hi_nxt          = hi_dec;
        if (lo_inc < hi_dec) begin
          state_nxt = S_REV_RD;
        end else begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

endmodule

// ===== design/lifo_stack_with_reverse.sv =====
// push, and reverse of fewer than two entries: result registered in the cycle after accept
// pop and peek: one synchronous memory read is registered, then the output register loads
// reverse of n entries: floor(n/2) pairs, read then written twice on the single write port
// one request in flight; the next is taken once the output register is empty or draining
// synchronous active-low reset empties the stack and clears out_valid; memory is not cleared
module lifo_stack_with_reverse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  lsr_pkg::lsr_in_t  in_data,
  output logic              in_stall,
  output logic              out_valid,
  output lsr_pkg::lsr_out_t out_data,
  input  logic              out_stall
);
  import lsr_pkg::*;

  lsr_mem_req_t      mem_req;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  logic              res_load;
  lsr_out_t          res_data;
  logic              out_free;

  logic     out_valid_r, out_valid_nxt;
  lsr_out_t out_data_r, out_data_nxt;

  assign out_free = !out_valid_r || !out_stall;

  lsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_free (out_free),
    .res_load (res_load),
    .res_data (res_data),
    .mem_req  (mem_req),
    .rd_a     (rd_a),
    .rd_b     (rd_b)
  );

  lsr_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/lsr_checker.sv =====
`include "lifo_stack_with_reverse_assert.svh"

module lsr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input lsr_pkg::lsr_out_t out_data,
  input logic              out_stall
);
  import lsr_pkg::*;

  `LSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `LSR_ASSERT_NOW(a_in_blocked, out_valid && out_stall, in_stall, "request taken while result blocked")
  `LSR_ASSERT_NOW(a_overflow_full, out_valid && (out_data.status == ST_OVERFLOW), (out_data.entry_count == COUNT_FULL) && (out_data.result_value == '0), "overflow on a stack not full")
  `LSR_ASSERT_NOW(a_empty_zero, out_valid && (out_data.status == ST_EMPTY), (out_data.entry_count == '0) && (out_data.result_value == '0), "empty status with entries held")

endmodule

bind lifo_stack_with_reverse lsr_checker u_lsr_checker (.*);
